// ----- design/hsv_pkg.sv -----
package hsv_pkg;

   // Field widths
   localparam int HUE_W = 10;
   localparam int PCT_W = 7;
   localparam int CHAN_W = 20;
   localparam int PROD_W = 14;
   localparam int HUE_WRAP_W = 9;
   localparam int FRAC_W = 6;

   // Scale constants
   localparam int DEG_FULL = 360;
   localparam int DEG_SECTOR = 60;
   localparam int PCT_FULL = 100;
   localparam int UNIT_PER_PCT = 6000;
   localparam int FULL_SCALE = 600000;

   // 60-degree hue sectors, named by the color at their start
   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } sector_type;

   // After wrap and saturation product
   typedef struct packed {
      logic [HUE_WRAP_W-1:0] hue_wrap;
      logic [PROD_W-1:0]     vs;
      logic [PCT_W-1:0]      v;
   } wrap_type;

   // After sector split
   typedef struct packed {
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic [PROD_W-1:0] vs;
      logic [PCT_W-1:0]  v;
   } sect_type;

   // After scaling to output units
   typedef struct packed {
      sector_type        sector;
      logic [CHAN_W-1:0] chroma;
      logic [CHAN_W-1:0] second;
      logic [CHAN_W-1:0] value;
   } scale_type;

   // Saturate a percent field to 100
   function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] raw);
      logic [PCT_W-1:0] lim;
      lim = PCT_W'(PCT_FULL);
      return (raw > lim) ? lim : raw;
   endfunction

endpackage

// ----- design/hsv_req_if.sv -----
interface hsv_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [hsv_pkg::HUE_W-1:0] hue;
   logic [hsv_pkg::PCT_W-1:0]        saturation;
   logic [hsv_pkg::PCT_W-1:0]        brightness;

   modport source(output valid, output hue, output saturation, output brightness,
                  input ready);
   modport sink(input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

// ----- design/hsv_rsp_if.sv -----
interface hsv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hsv_pkg::CHAN_W-1:0] red;
   logic [hsv_pkg::CHAN_W-1:0] green;
   logic [hsv_pkg::CHAN_W-1:0] blue;

   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ----- design/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, four register stages: hue wrap, sector, scale, mix.
// A request word passes the wrap, sector, scale and mix registers in turn.
// One word per cycle; a stalled response holds the pipe in place
// through a per-stage valid/ready chain.
// Reset: synchronous, active high; clears all stage valid bits, pipe empty.
module hsv_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   hsv_req_if.sink     req,
   hsv_rsp_if.source   rsp
);

   logic               front_valid;
   logic               front_ready;
   hsv_pkg::sect_type  front_word;
   logic               scale_valid;
   logic               scale_ready;
   hsv_pkg::scale_type scale_word;

   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_hue    (req.hue),
      .in_sat    (req.saturation),
      .in_bri    (req.brightness),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   hsv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_word  (scale_word)
   );

   hsv_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_ready  (scale_ready),
      .in_word   (scale_word),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_red   (rsp.red),
      .out_green (rsp.green),
      .out_blue  (rsp.blue)
   );

`ifndef SYNTHESIS
   // Channels never exceed full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.red <= 20'(hsv_pkg::FULL_SCALE))
                 && (rsp.green <= 20'(hsv_pkg::FULL_SCALE))
                 && (rsp.blue <= 20'(hsv_pkg::FULL_SCALE)))
      else $error("response channel above full scale");

   // With no back-pressure, an accepted request word shows up as a valid response word
   assert property (@(posedge clock) disable iff (reset)
      ($past(req.valid && req.ready, 4) && !$past(reset, 4) && !$past(reset, 3)
       && !$past(reset, 2) && !$past(reset, 1)
       && $past(rsp.ready, 1) && $past(rsp.ready, 2) && $past(rsp.ready, 3))
      |-> rsp.valid)
      else $error("request word lost in pipeline");

   // A full, stalled pipe takes no new request word
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready && scale_valid && front_valid
       && u_front.wrap_valid_ff) |-> !req.ready)
      else $error("request accepted while pipeline full and stalled");
`endif

endmodule

// ----- design/hsv_front.sv -----
module hsv_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [hsv_pkg::HUE_W-1:0] in_hue,
   input  logic [hsv_pkg::PCT_W-1:0]        in_sat,
   input  logic [hsv_pkg::PCT_W-1:0]        in_bri,
   output logic                             out_valid,
   input  logic                             out_ready,
   output hsv_pkg::sect_type                out_word
);

   localparam logic [10:0] HUE_OFFSET = 11'(2 * hsv_pkg::DEG_FULL);
   localparam logic [10:0] HUE_FULL = 11'(hsv_pkg::DEG_FULL);

   logic                        wrap_valid_ff;
   hsv_pkg::wrap_type           wrap_ff;
   hsv_pkg::wrap_type           wrap_in;
   logic                        wrap_ready;
   logic                        sect_valid_ff;
   hsv_pkg::sect_type           sect_ff;
   hsv_pkg::sect_type           sect_in;
   logic                        sect_ready;
   logic signed [11:0]          hue_pos;
   logic [10:0]                 hue_step;
   logic [hsv_pkg::PCT_W-1:0]   sat_c;
   logic [hsv_pkg::PCT_W-1:0]   bri_c;
   logic [hsv_pkg::HUE_WRAP_W-1:0] base;
   logic [hsv_pkg::HUE_WRAP_W-1:0] rem;

   assign sect_ready = !sect_valid_ff || out_ready;
   assign wrap_ready = !wrap_valid_ff || sect_ready;
   assign in_ready = wrap_ready;

   // Wrap hue into 0..359 and form v*s
   always_comb begin
      hue_pos = {{2{in_hue[hsv_pkg::HUE_W-1]}}, in_hue} + 12'sd720;
      hue_step = hue_pos[10:0];
      if (hue_step >= HUE_OFFSET) begin
         hue_step = hue_step - HUE_OFFSET;
      end
      if (hue_step >= HUE_FULL) begin
         hue_step = hue_step - HUE_FULL;
      end
      sat_c = hsv_pkg::clamp_pct(in_sat);
      bri_c = hsv_pkg::clamp_pct(in_bri);
      wrap_in.hue_wrap = hue_step[hsv_pkg::HUE_WRAP_W-1:0];
      wrap_in.vs = {{(hsv_pkg::PROD_W-hsv_pkg::PCT_W){1'b0}}, bri_c}
                 * {{(hsv_pkg::PROD_W-hsv_pkg::PCT_W){1'b0}}, sat_c};
      wrap_in.v = bri_c;
   end

   // Pick the sector and the rising/falling ramp within it
   always_comb begin
      if (wrap_ff.hue_wrap >= 9'(5 * hsv_pkg::DEG_SECTOR)) begin
         sect_in.sector = hsv_pkg::SECTOR_MAGENTA;
      end else if (wrap_ff.hue_wrap >= 9'(4 * hsv_pkg::DEG_SECTOR)) begin
         sect_in.sector = hsv_pkg::SECTOR_BLUE;
      end else if (wrap_ff.hue_wrap >= 9'(3 * hsv_pkg::DEG_SECTOR)) begin
         sect_in.sector = hsv_pkg::SECTOR_CYAN;
      end else if (wrap_ff.hue_wrap >= 9'(2 * hsv_pkg::DEG_SECTOR)) begin
         sect_in.sector = hsv_pkg::SECTOR_GREEN;
      end else if (wrap_ff.hue_wrap >= 9'(hsv_pkg::DEG_SECTOR)) begin
         sect_in.sector = hsv_pkg::SECTOR_YELLOW;
      end else begin
         sect_in.sector = hsv_pkg::SECTOR_RED;
      end
      case (sect_in.sector)
         hsv_pkg::SECTOR_RED:     base = 9'd0;
         hsv_pkg::SECTOR_YELLOW:  base = 9'(hsv_pkg::DEG_SECTOR);
         hsv_pkg::SECTOR_GREEN:   base = 9'(2 * hsv_pkg::DEG_SECTOR);
         hsv_pkg::SECTOR_CYAN:    base = 9'(3 * hsv_pkg::DEG_SECTOR);
         hsv_pkg::SECTOR_BLUE:    base = 9'(4 * hsv_pkg::DEG_SECTOR);
         default:                 base = 9'(5 * hsv_pkg::DEG_SECTOR);
      endcase
      rem = wrap_ff.hue_wrap - base;
      // odd sectors fall, even sectors rise
      if (sect_in.sector[0]) begin
         sect_in.frac = 6'(hsv_pkg::DEG_SECTOR) - rem[hsv_pkg::FRAC_W-1:0];
      end else begin
         sect_in.frac = rem[hsv_pkg::FRAC_W-1:0];
      end
      sect_in.vs = wrap_ff.vs;
      sect_in.v = wrap_ff.v;
   end

   // Advance both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
         sect_valid_ff <= 1'b0;
      end else begin
         if (wrap_ready) begin
            wrap_valid_ff <= in_valid;
         end
         if (sect_ready) begin
            sect_valid_ff <= wrap_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wrap_ready && in_valid) begin
         wrap_ff <= wrap_in;
      end
      if (sect_ready && wrap_valid_ff) begin
         sect_ff <= sect_in;
      end
   end

   assign out_valid = sect_valid_ff;
   assign out_word = sect_ff;

endmodule

// ----- design/hsv_scale.sv -----
module hsv_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hsv_pkg::sect_type  in_word,
   output logic               out_valid,
   input  logic               out_ready,
   output hsv_pkg::scale_type out_word
);

   localparam int PadVs = hsv_pkg::CHAN_W - hsv_pkg::PROD_W;
   localparam int PadV = hsv_pkg::CHAN_W - hsv_pkg::PCT_W;

   logic               valid_ff;
   hsv_pkg::scale_type word_ff;
   hsv_pkg::scale_type word_in;

   assign in_ready = !valid_ff || out_ready;

   // Scale chroma, second component and value to output units
   always_comb begin
      word_in.sector = in_word.sector;
      word_in.chroma = {{PadVs{1'b0}}, in_word.vs} * 20'(hsv_pkg::DEG_SECTOR);
      word_in.second = {{PadVs{1'b0}}, in_word.vs}
                     * {{(hsv_pkg::CHAN_W-hsv_pkg::FRAC_W){1'b0}}, in_word.frac};
      word_in.value = {{PadV{1'b0}}, in_word.v} * 20'(hsv_pkg::UNIT_PER_PCT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;

endmodule

// ----- design/hsv_mix.sv -----
module hsv_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hsv_pkg::scale_type         in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [hsv_pkg::CHAN_W-1:0] out_red,
   output logic [hsv_pkg::CHAN_W-1:0] out_green,
   output logic [hsv_pkg::CHAN_W-1:0] out_blue
);

   logic                       valid_ff;
   logic [hsv_pkg::CHAN_W-1:0] red_ff;
   logic [hsv_pkg::CHAN_W-1:0] green_ff;
   logic [hsv_pkg::CHAN_W-1:0] blue_ff;
   logic [hsv_pkg::CHAN_W-1:0] red_in;
   logic [hsv_pkg::CHAN_W-1:0] green_in;
   logic [hsv_pkg::CHAN_W-1:0] blue_in;
   logic [hsv_pkg::CHAN_W-1:0] offset;
   logic [hsv_pkg::CHAN_W-1:0] r_sel;
   logic [hsv_pkg::CHAN_W-1:0] g_sel;
   logic [hsv_pkg::CHAN_W-1:0] b_sel;

   assign in_ready = !valid_ff || out_ready;

   // Place chroma and second component by sector, then add v - C
   always_comb begin
      offset = in_word.value - in_word.chroma;
      case (in_word.sector)
         hsv_pkg::SECTOR_RED: begin
            r_sel = in_word.chroma; g_sel = in_word.second; b_sel = '0;
         end
         hsv_pkg::SECTOR_YELLOW: begin
            r_sel = in_word.second; g_sel = in_word.chroma; b_sel = '0;
         end
         hsv_pkg::SECTOR_GREEN: begin
            r_sel = '0; g_sel = in_word.chroma; b_sel = in_word.second;
         end
         hsv_pkg::SECTOR_CYAN: begin
            r_sel = '0; g_sel = in_word.second; b_sel = in_word.chroma;
         end
         hsv_pkg::SECTOR_BLUE: begin
            r_sel = in_word.second; g_sel = '0; b_sel = in_word.chroma;
         end
         default: begin
            r_sel = in_word.chroma; g_sel = '0; b_sel = in_word.second;
         end
      endcase
      red_in = r_sel + offset;
      green_in = g_sel + offset;
      blue_in = b_sel + offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red = red_ff;
   assign out_green = green_ff;
   assign out_blue = blue_ff;

endmodule
